@@ rtl/core/subset_sum_reachability_unit_assert.svh @@
// Assertion macros shared by the subset-sum reachability RTL
`ifndef SUBSET_SUM_REACHABILITY_UNIT_ASSERT_SVH
`define SUBSET_SUM_REACHABILITY_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ssr_pkg.sv @@
// Shared constants, types and helpers for the subset-sum reachability unit
package ssr_pkg;

    localparam int MAX_SUM   = 4095;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (MAX_SUM + WORD_BITS) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int STEP_W    = $clog2(MAP_WORDS + 1);
    localparam int SUM_W     = $clog2(MAX_SUM + 1);
    localparam int ACC_W     = $clog2(MAX_SUM + 2);
    localparam int POP_W     = $clog2(WORD_BITS + 1);
    localparam int OP_W      = 2;
    localparam int VALUE_W   = 12;
    localparam int COUNT_W   = 12;
    localparam int COUNT_MAX = 4095;
    localparam int TOP_BITS  = (MAX_SUM % WORD_BITS) + 1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_W-1:0]    t_addr;

    localparam t_word WORD_ONES = {WORD_BITS{1'b1}};
    localparam t_word WORD_ONE  = t_word'(1);
    // sums above the maximum never live in the top word
    localparam t_word TOP_MASK  = WORD_ONES >> (WORD_BITS - TOP_BITS);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    function automatic logic [POP_W-1:0] popcount(input t_word w);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + POP_W'(w[i]);
        end
        return n;
    endfunction

endpackage

@@ rtl/core/ssr_in_if.sv @@
// Input channel: op and value beats with valid/ready
interface ssr_in_if;
    import ssr_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

@@ rtl/core/ssr_out_if.sv @@
// Output channel: result beats with valid/ready
interface ssr_out_if;
    import ssr_pkg::*;

    logic               valid;
    logic               ready;
    logic               reachable;
    logic [COUNT_W-1:0] reach_count;
    logic               dropped;

    modport source (output valid, output reachable, output reach_count, output dropped,
                    input ready);
    modport sink   (input valid, input reachable, input reach_count, input dropped,
                    output ready);
endinterface

@@ rtl/core/subset_sum_reachability_unit.sv @@
// Subset-sum reachability unit: bitmap of reachable sums held in a word RAM
//
//   channel  | dir | beat payload                      | handshake
//   ---------+-----+-----------------------------------+-------------
//   i_in     | in  | op, value                         | valid/ready
//   o_out    | out | reachable, reach_count, dropped   | valid/ready
//
// Sweep: an add does one read-modify-write of every bitmap word through the single
// RAM write port.
// One item is in flight at a time; the next can be taken as its result is presented.
// Reset: synchronous; per-word valid flops clear at once, no clearing pass.
// Stalls: a waiting beat holds in the output register, the next result in finish.

`include "subset_sum_reachability_unit_assert.svh"

module subset_sum_reachability_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssr_in_if.sink    i_in,
    ssr_out_if.source o_out
);
    import ssr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QRY,
        ST_ADD,
        ST_DRAIN,
        ST_FIN
    } t_state;

    t_state               r_state;

    // item held for the duration of its work
    logic [VALUE_W-1:0]   r_value;
    t_addr                r_q;          // word part of the shift
    logic [BIT_W-1:0]     r_r;          // bit part of the shift
    t_addr                r_thr_w;      // last sum that survives, word part
    logic [BIT_W-1:0]     r_thr_b;      // ... and bit part
    logic                 r_hit;

    // architectural state besides the bitmap
    logic [MAP_WORDS-1:0] r_wvalid;     // word has been written since clear
    logic [COUNT_W-1:0]   r_count;
    logic                 r_lost;

    // sweep pipeline
    logic [STEP_W-1:0]    r_k;          // issue step
    logic                 r_s1_vld;     // read data of step r_s1_k present
    logic [STEP_W-1:0]    r_s1_k;
    logic                 r_a_inr;
    logic                 r_a_wv;
    logic                 r_a_zero;
    logic                 r_b_wv;
    logic                 r_b_zero;
    t_word                r_ap;         // source word of the previous step
    t_word                r_bp;         // destination word of the previous step
    logic                 r_p_vld;
    t_word                r_p_word;
    logic [ACC_W-1:0]     r_acc;

    // output register
    logic                 r_out_vld;
    logic                 r_out_hit;
    logic [COUNT_W-1:0]   r_out_cnt;
    logic                 r_out_drop;

    logic                 accept;
    logic                 v_in_range;
    logic [SUM_W-1:0]     thr;
    logic [STEP_W:0]      qk;
    logic                 a_inr;
    t_addr                a_idx;
    t_addr                b_idx;
    t_addr                rd_addr_b;
    t_word                rd_a;
    t_word                rd_b;
    t_word                a_cur;
    t_word                b_cur;
    t_addr                tgt;
    t_word                shifted;
    t_word                lmask;
    logic                 n_we;
    t_word                n_word;
    t_word                n_pword;
    logic [COUNT_W-1:0]   n_count;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign v_in_range = (32'(i_in.value) <= MAX_SUM);

    always_comb begin
        thr = SUM_W'(MAX_SUM) - SUM_W'(i_in.value);

        // Step k reads source word MAP_WORDS-1-q-k and destination word
        // MAP_WORDS-1-k; a source below word zero reads as empty.
        qk        = (STEP_W+1)'(r_q) + (STEP_W+1)'(r_k);
        a_inr     = qk < (STEP_W+1)'(MAP_WORDS);
        a_idx     = ADDR_W'((STEP_W+1)'(MAP_WORDS - 1) - qk);
        b_idx     = ADDR_W'(STEP_W'(MAP_WORDS - 1) - r_k);
        rd_addr_b = (r_state == ST_ADD) ? b_idx : ADDR_W'(i_in.value >> BIT_W);

        // a word never written since clear reads as its reset value
        a_cur = r_a_inr ? (r_a_wv ? rd_a : (r_a_zero ? WORD_ONE : '0)) : '0;
        b_cur = r_b_wv ? rd_b : (r_b_zero ? WORD_ONE : '0);

        // Target word w combines old[w] with old[w-q] << r and the spill
        // of old[w-q-1]. Writes walk downward and every later read is at a
        // lower word, so nothing read is ever stale.
        tgt     = ADDR_W'(STEP_W'(MAP_WORDS) - r_s1_k);
        n_we    = r_s1_vld && (r_s1_k != '0);
        shifted = (r_ap << r_r)
                | ((r_r != '0) ? (a_cur >> ((BIT_W+1)'(WORD_BITS) - (BIT_W+1)'(r_r)))
                               : '0);
        n_word  = (r_bp | shifted)
                & ((tgt == ADDR_W'(MAP_WORDS - 1)) ? TOP_MASK : WORD_ONES);
        // sum zero is not counted
        n_pword = n_word & ~((tgt == '0) ? WORD_ONE : '0);

        // old sums above the threshold overflow when shifted
        if (tgt > r_thr_w) begin
            lmask = WORD_ONES;
        end else if (tgt == r_thr_w) begin
            lmask = WORD_ONES << ((BIT_W+1)'(r_thr_b) + (BIT_W+1)'(1));
        end else begin
            lmask = '0;
        end

        n_count = (32'(r_acc) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(r_acc);
    end

    ssr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_we      (n_we),
        .i_waddr   (tgt),
        .i_wdata   (n_word),
        .i_raddr_a (a_idx),
        .o_rdata_a (rd_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wvalid  <= '0;
            r_count   <= '0;
            r_lost    <= 1'b0;
            r_k       <= '0;
            r_s1_vld  <= 1'b0;
            r_p_vld   <= 1'b0;
            r_acc     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // valid flags travel with the RAM read data
            r_a_inr  <= (r_state == ST_ADD) && a_inr;
            r_a_wv   <= r_wvalid[a_idx];
            r_a_zero <= (a_idx == '0);
            r_b_wv   <= r_wvalid[rd_addr_b];
            r_b_zero <= (rd_addr_b == '0);

            // advance the sweep pipeline
            r_s1_vld <= (r_state == ST_ADD);
            r_s1_k   <= r_k;
            if (r_s1_vld) begin
                r_ap <= a_cur;
                r_bp <= b_cur;
            end
            if (n_we) begin
                r_wvalid[tgt] <= 1'b1;
                if (|(r_bp & lmask)) begin
                    r_lost <= 1'b1;
                end
            end
            r_p_vld  <= n_we;
            r_p_word <= n_pword;
            if (r_p_vld) begin
                r_acc <= r_acc + ACC_W'(popcount(r_p_word));
            end

            // drop the output beat once taken
            if (r_out_vld && o_out.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_value <= i_in.value;
                        r_q     <= ADDR_W'(i_in.value >> BIT_W);
                        r_r     <= i_in.value[BIT_W-1:0];
                        r_thr_w <= ADDR_W'(thr >> BIT_W);
                        r_thr_b <= thr[BIT_W-1:0];
                        r_hit   <= 1'b0;
                        case (i_in.op)
                            OP_CLEAR: begin
                                r_wvalid <= '0;
                                r_count  <= '0;
                                r_lost   <= 1'b0;
                                r_state  <= ST_FIN;
                            end
                            OP_ADD: begin
                                if (i_in.value == '0) begin
                                    r_state <= ST_FIN;
                                end else if (!v_in_range) begin
                                    // sum zero alone already overflows
                                    r_lost  <= 1'b1;
                                    r_state <= ST_FIN;
                                end else begin
                                    r_k     <= '0;
                                    r_acc   <= '0;
                                    r_state <= ST_ADD;
                                end
                            end
                            OP_QUERY: begin
                                r_state <= v_in_range ? ST_QRY : ST_FIN;
                            end
                            default: begin
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_QRY: begin
                    r_hit   <= b_cur[r_value[BIT_W-1:0]];
                    r_state <= ST_FIN;
                end
                ST_ADD: begin
                    if (r_k == STEP_W'(MAP_WORDS)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_k <= r_k + STEP_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!r_s1_vld && !r_p_vld) begin
                        r_count <= n_count;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_out_vld || o_out.ready) begin
                        r_out_vld  <= 1'b1;
                        r_out_hit  <= r_hit;
                        r_out_cnt  <= r_count;
                        r_out_drop <= r_lost;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.reachable   = r_out_hit;
    assign o_out.reach_count = r_out_cnt;
    assign o_out.dropped     = r_out_drop;

    // RAM is written only by the sweep
    `SSR_ASSERT_NOW(a_write_in_sweep, i_clk, i_rst_n, n_we, (r_state == ST_ADD || r_state == ST_DRAIN), "bitmap write outside an add sweep")
    // during the add sweep, the word being written is never one being read in the same cycle
    `SSR_ASSERT_NOW(a_no_rw_overlap, i_clk, i_rst_n, (n_we && r_state == ST_ADD), ((tgt != rd_addr_b) && (!a_inr || tgt != a_idx)), "sweep reads a word it is writing")
    // a written word is marked valid
    `SSR_ASSERT_NEXT(a_write_marks_valid, i_clk, i_rst_n, n_we, r_wvalid[$past(tgt)], "written word not marked valid")
    // the dropped flag falls only through a clear
    `SSR_ASSERT_NOW(a_lost_sticky, i_clk, i_rst_n, $fell(r_lost), $past(accept && i_in.op == OP_CLEAR), "dropped flag fell without a clear")

endmodule

@@ rtl/core/ssr_ram.sv @@
// Generic RAM: one write port, two registered read ports
module ssr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]                             o_rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                             o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
